@@ sv/rws_pkg.sv @@
// Shared types and constants for the roulette wheel selector.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package rws_pkg;

	// Population and field sizes.
	localparam int POP_SIZE = 16;
	localparam int IDX_W    = 4;
	localparam int PTR_W    = $clog2(POP_SIZE);
	localparam int W_W      = 16;
	localparam int RND_W    = 31;
	// The total of all weights fits in SUM_W bits.
	localparam int SUM_W    = W_W + $clog2(POP_SIZE);
	localparam int ACC_W    = SUM_W + 1;
	// One counter serves the sum pass, the modulo steps and the walk.
	localparam int CNT_W    = ($clog2(RND_W) > PTR_W) ? $clog2(RND_W) : PTR_W + 1;

	// Operation codes.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [IDX_W-1:0] weight_index;
		logic [W_W-1:0]   new_weight;
		logic [RND_W-1:0] random_value;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] selected_index;
		logic             zero_total_error;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture a request, apply a weight write, clear the sum
		logic sum_step;   // add one weight to the total
		logic mod_init;   // clear the remainder and the counter
		logic mod_step;   // one restoring modulo step
		logic walk_init;  // clear the running sum and the counter
		logic walk_step;  // advance the walk by one member
		logic res_zero;   // result becomes index 0, no error
		logic res_err;    // result becomes index 0 with the error flag
		logic res_hit;    // result becomes the current member
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sum_last;
		logic mod_last;
		logic walk_last;
		logic total_zero;
		logic hit;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ sv/rws_ctrl.sv @@
// Controller state machine of the roulette wheel selector.
// Depends on rws_pkg for the command and status structs.
`default_nettype none

module rws_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              operation,
	input  wire rws_pkg::dp_stat_t stat,
	output rws_pkg::dp_cmd_t       cmd,
	output logic                   busy,
	output logic                   done
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SUM    = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_MOD    = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_RESULT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (operation == rws_pkg::OP_WRITE) begin
						cmd.res_zero = 1'b1;
						state_d      = S_RESULT;
					end else begin
						state_d = S_SUM;
					end
				end
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (stat.sum_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.total_zero) begin
					cmd.res_err = 1'b1;
					state_d     = S_RESULT;
				end else begin
					cmd.mod_init = 1'b1;
					state_d      = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					cmd.walk_init = 1'b1;
					state_d       = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.hit) begin
					cmd.res_hit = 1'b1;
					state_d     = S_RESULT;
				end else if (stat.walk_last) begin
					cmd.res_zero = 1'b1;
					state_d      = S_RESULT;
				end
			end
			S_RESULT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESULT);

endmodule

`default_nettype wire

@@ sv/rws_dpath.sv @@
// Datapath of the roulette wheel selector: weight table, total, modulo and walk.
// Depends on rws_pkg for types, widths and the command and status structs.
`default_nettype none

module rws_dpath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rws_pkg::req_t    request,
	input  wire rws_pkg::dp_cmd_t cmd,
	output rws_pkg::dp_stat_t     stat,
	output rws_pkg::rsp_t         result
);

	logic [rws_pkg::W_W-1:0]   weight_q [rws_pkg::POP_SIZE];
	logic [rws_pkg::CNT_W-1:0] cnt_q;
	logic [rws_pkg::SUM_W-1:0] sum_q;
	logic [rws_pkg::SUM_W-1:0] rem_q;
	logic [rws_pkg::SUM_W-1:0] acc_q;
	logic [rws_pkg::RND_W-1:0] rnd_q;
	logic [rws_pkg::IDX_W-1:0] sel_q;
	logic                      err_q;

	logic [rws_pkg::W_W-1:0]   rd_weight;
	logic [rws_pkg::ACC_W-1:0] walk_sum;
	logic [rws_pkg::ACC_W-1:0] rem_shift;
	logic [rws_pkg::ACC_W-1:0] rem_diff;
	logic                      rem_ge;
	logic                      wr_in_range;

	// The counter addresses the weight table during the sum and the walk.
	assign rd_weight = weight_q[cnt_q[rws_pkg::PTR_W-1:0]];

	// Running cumulative weight and the test against the reduced value.
	assign walk_sum = {1'b0, acc_q} + rws_pkg::ACC_W'(rd_weight);

	// One restoring modulo step: shift in the next random bit, subtract if it fits.
	assign rem_shift = {rem_q, rnd_q[rws_pkg::RND_W-1]};
	assign rem_diff  = rem_shift - {1'b0, sum_q};
	assign rem_ge    = (rem_shift >= {1'b0, sum_q});

	assign wr_in_range = ({1'b0, request.weight_index} < (rws_pkg::IDX_W + 1)'(rws_pkg::POP_SIZE));

	// Status toward the controller.
	always_comb begin
		stat.sum_last   = (cnt_q == rws_pkg::CNT_W'(rws_pkg::POP_SIZE - 1));
		stat.mod_last   = (cnt_q == rws_pkg::CNT_W'(rws_pkg::RND_W - 1));
		stat.walk_last  = (cnt_q == rws_pkg::CNT_W'(rws_pkg::POP_SIZE - 1));
		stat.total_zero = (sum_q == '0);
		stat.hit        = (walk_sum > {1'b0, rem_q});
	end

	// Weight table; it resets to all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rws_pkg::POP_SIZE; i++) begin
				weight_q[i] <= '0;
			end
		end else if (cmd.load && request.operation == rws_pkg::OP_WRITE && wr_in_range) begin
			weight_q[request.weight_index[rws_pkg::PTR_W-1:0]] <= request.new_weight;
		end
	end

	// Counter shared by the sum, modulo and walk phases.
	always_ff @(posedge clk) begin
		if (cmd.load || cmd.mod_init || cmd.walk_init) begin
			cnt_q <= '0;
		end else if (cmd.sum_step || cmd.mod_step || cmd.walk_step) begin
			cnt_q <= cnt_q + rws_pkg::CNT_W'(1);
		end
	end

	// Total of all weights.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q <= '0;
		end else if (cmd.sum_step) begin
			sum_q <= sum_q + rws_pkg::SUM_W'(rd_weight);
		end
	end

	// Random value shifts out most significant bit first during the modulo.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rnd_q <= request.random_value;
		end else if (cmd.mod_step) begin
			rnd_q <= {rnd_q[rws_pkg::RND_W-2:0], 1'b0};
		end
	end

	// Remainder of the random value modulo the total.
	always_ff @(posedge clk) begin
		if (cmd.mod_init) begin
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			rem_q <= rem_ge ? rem_diff[rws_pkg::SUM_W-1:0] : rem_shift[rws_pkg::SUM_W-1:0];
		end
	end

	// Cumulative weight during the walk.
	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			acc_q <= '0;
		end else if (cmd.walk_step) begin
			acc_q <= walk_sum[rws_pkg::SUM_W-1:0];
		end
	end

	// Result register, held while the result is shown.
	always_ff @(posedge clk) begin
		if (cmd.res_zero) begin
			sel_q <= '0;
			err_q <= 1'b0;
		end else if (cmd.res_err) begin
			sel_q <= '0;
			err_q <= 1'b1;
		end else if (cmd.res_hit) begin
			sel_q <= rws_pkg::IDX_W'(cnt_q);
			err_q <= 1'b0;
		end
	end

	assign result.selected_index   = sel_q;
	assign result.zero_total_error = err_q;

endmodule

`default_nettype wire

@@ sv/roulette_wheel_selector.sv @@
// Top level of the roulette wheel selector: controller and datapath.
// Depends on rws_pkg, rws_ctrl and rws_dpath.
//
// A request is taken when start is high and busy is low; every request gives one result,
// shown for a single cycle with done high, and the receiver cannot stall it. A weight
// write goes into the table at the edge that takes it. A select sums the 16 weights one
// per cycle, checks the total (a zero total gives the error result), reduces the random
// value by a restoring modulo one bit per cycle and walks the members one per cycle
// until the cumulative weight passes the remainder or the last member is reached, then
// shows the result; the next request is taken in the idle cycle that follows. The shared
// step counter and the single weight read port make these phases run one after another.
`default_nettype none

module roulette_wheel_selector (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire rws_pkg::req_t request,
	output logic               busy,
	output logic               done,
	output rws_pkg::rsp_t      result
);

	rws_pkg::dp_cmd_t  cmd;
	rws_pkg::dp_stat_t stat;

	// Sequencer.
	rws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (request.operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	// Weight table and arithmetic.
	rws_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

endmodule

`default_nettype wire

@@ sv/rws_checker.sv @@
// Port-level checks for the roulette wheel selector, bound to the top level.
// Depends on rws_pkg and on the top level roulette_wheel_selector.
`default_nettype none

module rws_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire rws_pkg::req_t request,
	input wire logic          busy,
	input wire logic          done,
	input wire rws_pkg::rsp_t result
);

	// A result lasts exactly one cycle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A result only appears while a request is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	// A taken request keeps the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but block not busy");

	// A weight write answers in the next cycle with index 0 and no error.
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.operation == rws_pkg::OP_WRITE) |=>
		(done && !result.zero_total_error && result.selected_index == '0))
		else $error("weight write result wrong or late");

	// A zero total always reports index 0.
	a_err_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.zero_total_error) |-> (result.selected_index == '0))
		else $error("error result with nonzero index");

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.request (request),
	.busy    (busy),
	.done    (done),
	.result  (result)
);

`default_nettype wire

@@ tb/tb_roulette_wheel_selector.sv @@
// Self-checking testbench for roulette_wheel_selector: directed rows, then random requests.
// Depends on rws_pkg and the roulette_wheel_selector top level; results are checked in order.
`timescale 1ns / 1ps

module tb_roulette_wheel_selector;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASE_ITEMS  = 620;
	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		rws_pkg::req_t rq;
		bit            fixed;
		rws_pkg::rsp_t want;
	} stim_row_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          start;
	rws_pkg::req_t request;
	logic          busy;
	logic          done;
	rws_pkg::rsp_t result;

	// Local copy of the weight table and the picks still owed by the block.
	logic [rws_pkg::W_W-1:0] wheel_weights [rws_pkg::POP_SIZE];
	rws_pkg::rsp_t           expected_picks [$];
	stim_row_t               directed_rows [$];
	int                      mismatch_count = 0;
	int                      cycle_count = 0;

	roulette_wheel_selector dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Applies a request to the local table and works out the pick it should produce.
	function automatic rws_pkg::rsp_t predict_pick(rws_pkg::req_t rq);
		logic [rws_pkg::SUM_W-1:0] total;
		logic [rws_pkg::SUM_W-1:0] spot;
		logic [rws_pkg::SUM_W-1:0] running;
		rws_pkg::rsp_t             pick;
		bit                        found;
		pick    = '0;
		total   = '0;
		running = '0;
		found   = 1'b0;
		if (rq.operation == rws_pkg::OP_WRITE) begin
			if (rq.weight_index < rws_pkg::POP_SIZE)
				wheel_weights[rq.weight_index] = rq.new_weight;
		end else begin
			for (int i = 0; i < rws_pkg::POP_SIZE; i++)
				total += rws_pkg::SUM_W'(wheel_weights[i]);
			if (total == 0) begin
				pick.zero_total_error = 1'b1;
			end else begin
				spot = rws_pkg::SUM_W'(rq.random_value % total);
				// The first member whose cumulative weight passes the spot wins.
				for (int i = 0; i < rws_pkg::POP_SIZE; i++) begin
					running += rws_pkg::SUM_W'(wheel_weights[i]);
					if (!found && running > spot) begin
						pick.selected_index = rws_pkg::IDX_W'(i);
						found = 1'b1;
					end
				end
			end
		end
		return pick;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic add_row(input logic op, input int idx, input int w, input int r,
			input bit fixed, input int sel = 0, input bit err = 1'b0);
		stim_row_t row;
		row.rq.operation      = op;
		row.rq.weight_index   = idx[rws_pkg::IDX_W-1:0];
		row.rq.new_weight     = w[rws_pkg::W_W-1:0];
		row.rq.random_value   = r[rws_pkg::RND_W-1:0];
		row.fixed             = fixed;
		row.want.selected_index   = sel[rws_pkg::IDX_W-1:0];
		row.want.zero_total_error = err;
		directed_rows = {directed_rows, row};
	endtask

	// Holds a request on the port until it is taken, then books its expected pick.
	task automatic issue(input rws_pkg::req_t rq, input bit fixed = 1'b0,
			input rws_pkg::rsp_t want = '0);
		rws_pkg::rsp_t guess;
		start   <= 1'b1;
		request <= rq;
		do @(posedge clk); while (!(start && !busy));
		guess = predict_pick(rq);
		expected_picks = {expected_picks, (fixed ? want : guess)};
	endtask

	// Idles the sender cycle by cycle with the given odds, with junk on the request bus.
	task automatic sender_gap(input int pct);
		logic [63:0] junk;
		while ($urandom_range(99) < pct) begin
			junk = {$urandom, $urandom};
			start   <= 1'b0;
			request <= junk[$bits(rws_pkg::req_t)-1:0];
			@(posedge clk);
		end
	endtask

	// Holds off new requests until every outstanding pick has come back.
	task automatic drain_picks();
		start <= 1'b0;
		do @(posedge clk); while (expected_picks.size() != 0);
	endtask

	// Random request: mixed weights, with zeros and small values common.
	function automatic rws_pkg::req_t random_request();
		rws_pkg::req_t rq;
		int            roll;
		rq.operation    = ($urandom_range(99) < 45) ? rws_pkg::OP_WRITE : rws_pkg::OP_SELECT;
		rq.weight_index = rws_pkg::IDX_W'($urandom_range((1 << rws_pkg::IDX_W) - 1));
		roll = $urandom_range(99);
		if (roll < 25)
			rq.new_weight = '0;
		else if (roll < 50)
			rq.new_weight = rws_pkg::W_W'($urandom_range(15, 1));
		else if (roll < 90)
			rq.new_weight = rws_pkg::W_W'($urandom);
		else
			rq.new_weight = '1;
		roll = $urandom_range(99);
		if (roll < 75)
			rq.random_value = rws_pkg::RND_W'($urandom);
		else
			rq.random_value = rws_pkg::RND_W'($urandom_range(300000));
		return rq;
	endfunction

	// Every strobed result is compared with the oldest expected pick.
	always @(posedge clk) begin
		rws_pkg::rsp_t want;
		if (arst_n && done) begin
			if (expected_picks.size() == 0) begin
				flag_mismatch($sformatf("unrequested result index %0d error %0b",
					result.selected_index, result.zero_total_error));
			end else begin
				want = expected_picks.pop_front();
				if (result.selected_index !== want.selected_index)
					flag_mismatch($sformatf("selected_index %0d, wanted %0d",
						result.selected_index, want.selected_index));
				if (result.zero_total_error !== want.zero_total_error)
					flag_mismatch($sformatf("zero_total_error %0b, wanted %0b",
						result.zero_total_error, want.zero_total_error));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d picks outstanding",
				cycle_count, expected_picks.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int            idle_pct [3];
		int            sent;
		rws_pkg::req_t rq;
		idle_pct = '{32, 65, 0};
		start   <= 1'b0;
		request <= '0;
		arst_n  <= 1'b0;
		for (int i = 0; i < rws_pkg::POP_SIZE; i++)
			wheel_weights[i] = '0;

		// Directed rows: empty table, lone heavy member, wheel boundaries, all-ones fields.
		add_row(rws_pkg::OP_SELECT, 0, 0, 0, 1'b1, 0, 1'b1);
		add_row(rws_pkg::OP_SELECT, 15, 'hFFFF, 'h7FFFFFFF, 1'b1, 0, 1'b1);
		add_row(rws_pkg::OP_WRITE, 15, 'hFFFF, 0, 1'b1);
		add_row(rws_pkg::OP_SELECT, 0, 0, 0, 1'b1, 15);
		add_row(rws_pkg::OP_SELECT, 0, 0, 'h7FFFFFFF, 1'b1, 15);
		add_row(rws_pkg::OP_WRITE, 0, 1, 0, 1'b1);
		add_row(rws_pkg::OP_SELECT, 0, 0, 0, 1'b1, 0);
		add_row(rws_pkg::OP_SELECT, 0, 0, 1, 1'b1, 15);
		add_row(rws_pkg::OP_WRITE, 15, 0, 0, 1'b1);
		add_row(rws_pkg::OP_SELECT, 0, 0, 'h7FFFFFFF, 1'b1, 0);
		add_row(rws_pkg::OP_WRITE, 0, 0, 0, 1'b1);
		add_row(rws_pkg::OP_SELECT, 0, 0, 12345, 1'b1, 0, 1'b1);
		add_row(rws_pkg::OP_WRITE, 7, 5, 0, 1'b1);
		add_row(rws_pkg::OP_WRITE, 8, 3, 0, 1'b1);
		add_row(rws_pkg::OP_SELECT, 0, 0, 4, 1'b1, 7);
		add_row(rws_pkg::OP_SELECT, 0, 0, 5, 1'b1, 8);
		add_row(rws_pkg::OP_SELECT, 0, 0, 13, 1'b0);
		add_row(rws_pkg::OP_WRITE, 3, 'hAAAA, 'h2AAAAAAA, 1'b0);
		add_row(rws_pkg::OP_WRITE, 12, 'h5555, 'h55555555, 1'b0);
		add_row(rws_pkg::OP_SELECT, 5, 'h5555, 'h2AAAAAAA, 1'b0);
		add_row(rws_pkg::OP_SELECT, 10, 'hAAAA, 'h55555555, 1'b0);
		add_row(rws_pkg::OP_WRITE, 15, 'hFFFF, 'h7FFFFFFF, 1'b0);
		add_row(rws_pkg::OP_SELECT, 15, 'hFFFF, 'h7FFFFFFF, 1'b0);
		add_row(rws_pkg::OP_WRITE, 0, 0, 0, 1'b0);
		add_row(rws_pkg::OP_SELECT, 0, 0, 65535, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].rq, directed_rows[i].fixed, directed_rows[i].want);
		drain_picks();

		// Random phases: sender busy idling, heavy idling, then back to back.
		for (int ph = 0; ph < 3; ph++) begin
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(99) < 2) begin
					// Wipe the whole table so zero totals and sparse wheels show up.
					for (int k = 0; k < rws_pkg::POP_SIZE; k++) begin
						rq = random_request();
						rq.operation    = rws_pkg::OP_WRITE;
						rq.weight_index = rws_pkg::IDX_W'(k);
						rq.new_weight   = '0;
						sender_gap(idle_pct[ph]);
						issue(rq);
					end
					sent += rws_pkg::POP_SIZE;
				end else begin
					sender_gap(idle_pct[ph]);
					issue(random_request());
					sent++;
				end
			end
			drain_picks();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_picks.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
sv/rws_pkg.sv
sv/rws_ctrl.sv
sv/rws_dpath.sv
sv/roulette_wheel_selector.sv
sv/rws_checker.sv
tb/tb_roulette_wheel_selector.sv
